// ===== design/htfd_pkg.sv =====
// Package for the header/tail frame deframer: constants, codes and shared types.
package htfd_pkg;

    // Field widths
    localparam int HTFD_BYTE_W    = 8;
    localparam int HTFD_IDENT_W   = 16;
    localparam int HTFD_LEN_W     = 4;
    localparam int HTFD_PAYLOAD_W = 64;
    localparam int HTFD_CFG_IDX_W = 2;

    // Default payload capacity and the fixed frame overhead
    localparam int HTFD_MAX_PAYLOAD = 8;
    localparam int HTFD_MIN_FRAME   = 2 + 1 + 4 + 1 + 2;

    // Byte offsets inside a frame
    localparam int OFS_HDR0    = 0;
    localparam int OFS_HDR1    = 1;
    localparam int OFS_CHANNEL = 2;
    localparam int OFS_TYPE    = 3;
    localparam int OFS_ID_HI   = 4;
    localparam int OFS_ID_LO   = 5;
    localparam int OFS_MASTER  = 6;
    localparam int OFS_LEN     = 7;
    localparam int OFS_PAYLOAD = 8;

    // Configuration register indexes
    typedef enum logic [HTFD_CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_TAIL_FIRST    = 2'd2,
        CFG_TAIL_SECOND   = 2'd3
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_SEARCH,
        ST_CHECK,
        ST_DRAIN
    } t_state;

    // Frame markers from the configuration registers
    typedef struct packed {
        logic [HTFD_BYTE_W-1:0] hdr_first;
        logic [HTFD_BYTE_W-1:0] hdr_second;
        logic [HTFD_BYTE_W-1:0] tail_first;
        logic [HTFD_BYTE_W-1:0] tail_second;
    } t_marks;

    // Buffer commands from the sequencer (at most one set per cycle)
    typedef struct packed {
        logic push;
        logic shift;
        logic clear;
    } t_buf_ctl;

    // Buffer status seen by the sequencer
    typedef struct packed {
        logic enough;       // at least a minimal frame held
        logic pair_ok;      // header pair sits at the front
        logic few;          // one byte or none held
        logic dlc_bad;      // length byte above capacity
        logic frame_short;  // frame not yet complete
        logic tail_ok;      // tail pair matches at the length-given place
    } t_buf_stat;

    // One decoded frame
    typedef struct packed {
        logic [HTFD_BYTE_W-1:0]    channel;
        logic [HTFD_BYTE_W-1:0]    msg_type;
        logic [HTFD_IDENT_W-1:0]   ident;
        logic [HTFD_BYTE_W-1:0]    master_ident;
        logic [HTFD_LEN_W-1:0]     payload_length;
        logic [HTFD_PAYLOAD_W-1:0] payload;
    } t_frame;

endpackage

// ===== design/htfd_in_if.sv =====
// Byte input channel of the deframer.
interface htfd_in_if;
    import htfd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [HTFD_BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/htfd_out_if.sv =====
// Frame output channel of the deframer.
interface htfd_out_if;
    import htfd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [HTFD_BYTE_W-1:0]    channel;
    logic [HTFD_BYTE_W-1:0]    msg_type;
    logic [HTFD_IDENT_W-1:0]   ident;
    logic [HTFD_BYTE_W-1:0]    master_ident;
    logic [HTFD_LEN_W-1:0]     payload_length;
    logic [HTFD_PAYLOAD_W-1:0] payload;

    modport source (output valid, output channel, output msg_type, output ident,
                    output master_ident, output payload_length, output payload,
                    input ready);
    modport sink   (input valid, input channel, input msg_type, input ident,
                    input master_ident, input payload_length, input payload,
                    output ready);
endinterface

// ===== design/htfd_buffer.sv =====
// Holding buffer: shift line of received bytes with front compares and frame decode.
module htfd_buffer #(
    parameter int MAX_PAYLOAD = htfd_pkg::HTFD_MAX_PAYLOAD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  htfd_pkg::t_buf_ctl            i_ctl,
    input  logic [htfd_pkg::HTFD_BYTE_W-1:0] i_byte,
    input  htfd_pkg::t_marks              i_marks,
    output htfd_pkg::t_buf_stat           o_stat,
    output htfd_pkg::t_frame              o_frame
);
    import htfd_pkg::*;

    localparam int Depth = MAX_PAYLOAD + HTFD_MIN_FRAME;
    localparam int CntW  = $clog2(Depth + 1);
    localparam int IdxW  = $clog2(Depth);

    logic [HTFD_BYTE_W-1:0] r_bytes [Depth];
    logic [CntW-1:0]        r_count;

    logic [HTFD_LEN_W-1:0]  w_dlc;
    logic [HTFD_BYTE_W-1:0] w_len_byte;
    logic [CntW-1:0]        w_flen;

    // Byte storage: append at the fill point, or move everything one place forward
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            if (r_count == CntW'(Depth)) begin
                for (int i = 0; i < Depth - 1; i++) begin
                    r_bytes[i] <= r_bytes[i+1];
                end
                r_bytes[Depth-1] <= i_byte;
            end else begin
                r_bytes[r_count[IdxW-1:0]] <= i_byte;
            end
        end else if (i_ctl.shift) begin
            for (int i = 0; i < Depth - 1; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.push) begin
            if (r_count != CntW'(Depth)) begin
                r_count <= r_count + CntW'(1);
            end
        end else if (i_ctl.shift) begin
            r_count <= r_count - CntW'(1);
        end
    end

    // Length byte and the frame length it implies (valid when not above capacity)
    assign w_len_byte = r_bytes[OFS_LEN];
    assign w_dlc      = w_len_byte[HTFD_LEN_W-1:0];
    assign w_flen     = CntW'(HTFD_MIN_FRAME) + CntW'(w_dlc);

    // Status for the sequencer
    always_comb begin
        o_stat.enough      = (r_count >= CntW'(HTFD_MIN_FRAME));
        o_stat.pair_ok     = (r_count >= CntW'(2))
                             && (r_bytes[OFS_HDR0] == i_marks.hdr_first)
                             && (r_bytes[OFS_HDR1] == i_marks.hdr_second);
        o_stat.few         = (r_count <= CntW'(1));
        o_stat.dlc_bad     = (w_len_byte > HTFD_BYTE_W'(MAX_PAYLOAD));
        o_stat.frame_short = (r_count < w_flen);
        o_stat.tail_ok     = 1'b0;
        for (int k = 0; k <= MAX_PAYLOAD; k++) begin
            if (w_dlc == HTFD_LEN_W'(k)) begin
                o_stat.tail_ok = (r_bytes[OFS_PAYLOAD + k] == i_marks.tail_first)
                                 && (r_bytes[OFS_PAYLOAD + k + 1] == i_marks.tail_second);
            end
        end
    end

    // Frame fields; payload bytes past the length read as zero
    always_comb begin
        o_frame.channel        = r_bytes[OFS_CHANNEL];
        o_frame.msg_type       = r_bytes[OFS_TYPE];
        o_frame.ident          = {r_bytes[OFS_ID_HI], r_bytes[OFS_ID_LO]};
        o_frame.master_ident   = r_bytes[OFS_MASTER];
        o_frame.payload_length = w_dlc;
        o_frame.payload        = '0;
        for (int k = 0; k < MAX_PAYLOAD; k++) begin
            if (HTFD_LEN_W'(k) < w_dlc) begin
                o_frame.payload[HTFD_BYTE_W*k +: HTFD_BYTE_W] = r_bytes[OFS_PAYLOAD + k];
            end
        end
    end

endmodule

// ===== design/header_tail_frame_deframer_top.sv =====
// Top level of the header/tail frame deframer: config registers, sequencer, output register.
//
//  Channel   Dir  Handshake      Payload
//  i_rx      in   valid/ready    rx_byte[7:0]
//  o_frame   out  valid/ready    channel, msg_type, ident[15:0], master_ident,
//                                payload_length[3:0], payload[63:0]
//  i_cfg_*   in   write enable   i_cfg_idx[1:0], i_cfg_data[7:0]
//
// Each byte is accepted, then a fill check follows, while fewer than 10 bytes are held.
// Otherwise the search drops one byte per cycle until a header pair leads (or flushes the
// buffer when at most one byte is left); a bad length or tail drops one byte and returns
// to the fill check, and a good frame is reported once the output register is free, then
// shifted out of the buffer. The holding buffer moves bytes with a single-step shift line.
// Reset (synchronous, active low) empties the buffer and zeroes the markers.
// A frame waits in the output register; a new frame stalls the sequencer until it is taken.
module header_tail_frame_deframer_top #(
    parameter int MAX_PAYLOAD = htfd_pkg::HTFD_MAX_PAYLOAD
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    htfd_in_if.sink                              i_rx,
    htfd_out_if.source                           o_frame,
    input  logic                                 i_cfg_we,
    input  logic [htfd_pkg::HTFD_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [htfd_pkg::HTFD_BYTE_W-1:0]     i_cfg_data
);
    import htfd_pkg::*;

    localparam int Depth = MAX_PAYLOAD + HTFD_MIN_FRAME;
    localparam int CntW  = $clog2(Depth + 1);

    t_marks    r_marks;
    t_state    r_state, n_state;
    logic [CntW-1:0] r_drain, n_drain;
    logic      r_out_valid;
    t_frame    r_frame;

    t_buf_ctl  w_ctl;
    t_buf_stat w_stat;
    t_frame    w_frame;
    logic      w_emit;
    logic      w_out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEADER_FIRST:  r_marks.hdr_first   <= i_cfg_data;
                CFG_HEADER_SECOND: r_marks.hdr_second  <= i_cfg_data;
                CFG_TAIL_FIRST:    r_marks.tail_first  <= i_cfg_data;
                CFG_TAIL_SECOND:   r_marks.tail_second <= i_cfg_data;
            endcase
        end
    end

    htfd_buffer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (i_rx.rx_byte),
        .i_marks (r_marks),
        .o_stat  (w_stat),
        .o_frame (w_frame)
    );

    assign w_out_free = !r_out_valid || o_frame.ready;
    assign i_rx.ready = (r_state == ST_IDLE);

    // Sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    // Next state and buffer commands
    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        w_ctl   = '0;
        w_emit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_rx.valid) begin
                    w_ctl.push = 1'b1;
                    n_state    = ST_TOP;
                end
            end
            ST_TOP: begin
                n_state = w_stat.enough ? ST_SEARCH : ST_IDLE;
            end
            ST_SEARCH: begin
                priority if (w_stat.pair_ok) begin
                    n_state = ST_CHECK;
                end else if (w_stat.few) begin
                    // no header anywhere: flush
                    w_ctl.clear = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    w_ctl.shift = 1'b1;
                end
            end
            ST_CHECK: begin
                priority if (!w_stat.enough) begin
                    n_state = ST_IDLE;
                end else if (w_stat.dlc_bad) begin
                    w_ctl.shift = 1'b1;
                    n_state     = ST_TOP;
                end else if (w_stat.frame_short) begin
                    n_state = ST_IDLE;
                end else if (!w_stat.tail_ok) begin
                    w_ctl.shift = 1'b1;
                    n_state     = ST_TOP;
                end else if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_drain = CntW'(HTFD_MIN_FRAME) + CntW'(w_frame.payload_length);
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // remove the reported frame one byte a cycle
                w_ctl.shift = 1'b1;
                n_drain     = r_drain - CntW'(1);
                if (r_drain == CntW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_frame <= w_frame;
        end
    end

    assign o_frame.valid          = r_out_valid;
    assign o_frame.channel        = r_frame.channel;
    assign o_frame.msg_type       = r_frame.msg_type;
    assign o_frame.ident          = r_frame.ident;
    assign o_frame.master_ident   = r_frame.master_ident;
    assign o_frame.payload_length = r_frame.payload_length;
    assign o_frame.payload        = r_frame.payload;

    // Checks
    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_frame.payload_length <= HTFD_LEN_W'(MAX_PAYLOAD)))
        else $error("reported length above capacity");

    a_drain_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_drain != '0))
        else $error("drain count empty while draining");

    a_short_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DRAIN) && (n_state == ST_IDLE)) |=> !w_stat.enough)
        else $error("a full frame still held after removing one");

endmodule

// ===== tb/header_tail_frame_deframer_checker.sv =====
// Scoreboard for the header/tail frame deframer: frame predictor and output comparison.
module header_tail_frame_deframer_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    htfd_in_if                                  rx_mon,
    htfd_out_if                                 frame_mon,
    input  logic                                i_cfg_we,
    input  logic [htfd_pkg::HTFD_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [htfd_pkg::HTFD_BYTE_W-1:0]    i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import htfd_pkg::*;

    localparam int HOLD_DEPTH = HTFD_MAX_PAYLOAD + HTFD_MIN_FRAME;

    // Shadow copy of the markers and of the holding buffer
    t_marks                 marks;
    logic [HTFD_BYTE_W-1:0] hold_buf [HOLD_DEPTH];
    int unsigned            hold_cnt = 0;
    t_frame                 frame_q [$];
    int                     fails = 0;

    // Remove n bytes from the front of the buffer
    function automatic void drop_front(int unsigned n);
        if (n >= hold_cnt) begin
            hold_cnt = 0;
        end else begin
            for (int unsigned i = 0; i < hold_cnt - n; i++)
                hold_buf[i] = hold_buf[i + n];
            hold_cnt = hold_cnt - n;
        end
    endfunction

    // Take one received byte, run the resync/parse rule, return 1 if a frame falls out
    function automatic bit deframe_byte(input logic [HTFD_BYTE_W-1:0] rx, output t_frame fr);
        int unsigned s;
        int unsigned dlc;
        int unsigned flen;
        bit          found;
        fr = '0;
        if (hold_cnt >= HOLD_DEPTH)
            drop_front(hold_cnt - HOLD_DEPTH + 1);
        hold_buf[hold_cnt] = rx;
        hold_cnt++;
        while (hold_cnt >= HTFD_MIN_FRAME) begin
            // header search
            found = 1'b0;
            for (s = 0; s + 1 < hold_cnt; s++) begin
                if (hold_buf[s] == marks.hdr_first && hold_buf[s + 1] == marks.hdr_second) begin
                    found = 1'b1;
                    break;
                end
            end
            if (!found) begin
                hold_cnt = 0;
                break;
            end
            if (s > 0) begin
                drop_front(s);
                if (hold_cnt < HTFD_MIN_FRAME)
                    break;
            end
            // length and tail checks
            dlc = hold_buf[OFS_LEN];
            if (dlc > HTFD_MAX_PAYLOAD) begin
                drop_front(1);
                continue;
            end
            flen = HTFD_MIN_FRAME + dlc;
            if (hold_cnt < flen)
                break;
            if (hold_buf[flen - 2] != marks.tail_first ||
                hold_buf[flen - 1] != marks.tail_second) begin
                drop_front(1);
                continue;
            end
            // good frame
            fr.channel        = hold_buf[OFS_CHANNEL];
            fr.msg_type       = hold_buf[OFS_TYPE];
            fr.ident          = {hold_buf[OFS_ID_HI], hold_buf[OFS_ID_LO]};
            fr.master_ident   = hold_buf[OFS_MASTER];
            fr.payload_length = dlc[HTFD_LEN_W-1:0];
            for (int unsigned k = 0; k < dlc; k++)
                fr.payload[8*k +: 8] = hold_buf[OFS_PAYLOAD + k];
            drop_front(flen);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Track config writes, compare delivered frames, predict on accepted bytes
    always @(posedge i_clk) begin : watch
        t_frame want;
        if (!i_rst_n) begin
            marks    = '0;
            hold_cnt = 0;
            frame_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HEADER_FIRST:  marks.hdr_first   = i_cfg_data;
                    CFG_HEADER_SECOND: marks.hdr_second  = i_cfg_data;
                    CFG_TAIL_FIRST:    marks.tail_first  = i_cfg_data;
                    CFG_TAIL_SECOND:   marks.tail_second = i_cfg_data;
                    default: ;
                endcase
            end
            if (frame_mon.valid && frame_mon.ready) begin
                if (frame_q.size() == 0) begin
                    fails++;
                    $display("%0t: no frame expected, got ch %h type %h id %h len %h pay %h",
                             $time, frame_mon.channel, frame_mon.msg_type, frame_mon.ident,
                             frame_mon.payload_length, frame_mon.payload);
                end else begin
                    want = frame_q.pop_front();
                    check_field("channel", want.channel, frame_mon.channel);
                    check_field("msg_type", want.msg_type, frame_mon.msg_type);
                    check_field("ident", want.ident, frame_mon.ident);
                    check_field("master_ident", want.master_ident, frame_mon.master_ident);
                    check_field("payload_length", want.payload_length,
                                frame_mon.payload_length);
                    check_field("payload", want.payload, frame_mon.payload);
                end
            end
            if (rx_mon.valid && rx_mon.ready) begin
                if (deframe_byte(rx_mon.rx_byte, want))
                    frame_q.insert(frame_q.size(), want);
            end
        end
        o_pending    <= frame_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/header_tail_frame_deframer_top_tb.sv =====
// Testbench top for the header/tail frame deframer: stimulus, handshake pacing and verdict.
module header_tail_frame_deframer_top_tb;
    import htfd_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int BYTES_PER_PHASE = 92;
    // worst byte cost of the block plus margin
    localparam int DRAIN_CYCLES    = 2 * (HTFD_MAX_PAYLOAD + HTFD_MIN_FRAME) + 24;

    typedef enum {SEQ_GOOD, SEQ_BAD_TAIL, SEQ_BAD_LEN, SEQ_CUT, SEQ_NOISE} t_seq_kind;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    t_cfg_idx               cfg_idx;
    logic [HTFD_BYTE_W-1:0] cfg_data;
    int                     fail_count;
    int                     pending;
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;
    t_marks                 marks;
    logic [HTFD_BYTE_W-1:0] seq_q [$];

    htfd_in_if  rx_if ();
    htfd_out_if frame_if ();

    header_tail_frame_deframer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_rx       (rx_if),
        .o_frame    (frame_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    header_tail_frame_deframer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .rx_mon       (rx_if),
        .frame_mon    (frame_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop
    initial begin
        #5_000_000;
        $display("header_tail_frame_deframer_top: mismatch");
        $finish;
    end

    // Random backpressure on the frame output
    always @(posedge clk) begin
        frame_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [HTFD_BYTE_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Append one byte to the pending sequence
    function automatic void put_byte(input logic [HTFD_BYTE_W-1:0] b);
        seq_q.insert(seq_q.size(), b);
    endfunction

    // Payload-ish byte; sometimes a marker value to provoke false syncs
    function automatic logic [HTFD_BYTE_W-1:0] pick_content();
        case ($urandom_range(15))
            0:       return marks.hdr_first;
            1:       return marks.hdr_second;
            2:       return marks.tail_first;
            3:       return marks.tail_second;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Header pair plus channel, type, id and master id
    function automatic void add_head();
        put_byte(marks.hdr_first);
        put_byte(marks.hdr_second);
        repeat (OFS_LEN - OFS_CHANNEL) put_byte(pick_content());
    endfunction

    // Whole frame; a bad tail corrupts one or both tail bytes
    function automatic void add_frame(input int unsigned len, input bit tail_good);
        logic [1:0] bad;
        bad = tail_good ? 2'b00 : 2'($urandom_range(3, 1));
        add_head();
        put_byte(8'(len));
        repeat (len) put_byte(pick_content());
        put_byte(marks.tail_first ^ (bad[0] ? 8'($urandom_range(255, 1)) : 8'h00));
        put_byte(marks.tail_second ^ (bad[1] ? 8'($urandom_range(255, 1)) : 8'h00));
    endfunction

    initial begin : stimulus
        int        phase_start;
        int        sent_count;
        int        roll;
        t_seq_kind kind;
        rx_if.valid    <= 1'b0;
        rx_if.rx_byte  <= '0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_HEADER_FIRST;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        sent_count     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // marker setting for this phase, extremes included
            case (ph)
                0:       marks = t_marks'(32'hAA55_0D0A);
                1:       marks = t_marks'(32'h0000_0000);
                2:       marks = t_marks'(32'hFFFF_FFFF);
                4:       marks = t_marks'(32'h7E7E_7E7E);
                6:       marks = t_marks'(32'h00FF_FF00);
                default: marks = t_marks'($urandom);
            endcase
            write_reg(CFG_HEADER_FIRST, marks.hdr_first);
            write_reg(CFG_HEADER_SECOND, marks.hdr_second);
            write_reg(CFG_TAIL_FIRST, marks.tail_first);
            write_reg(CFG_TAIL_SECOND, marks.tail_second);
            cfg_we <= 1'b0;

            // pacing: none, sender idle, receiver stall, both
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 71; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 71; end
                default: begin send_idle_pct = 18; stall_pct <= 18; end
            endcase

            // directed opener: noise, late header, oversize length, then a full
            // max-length frame with extreme field values
            if (ph == 0)
                seq_q = '{8'hFF, 8'h00,
                          8'hAA, 8'h55, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h0F,
                          8'hAA, 8'h55, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h08,
                          8'hFF, 8'h00, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h0F, 8'hF0,
                          8'h0D, 8'h0A};

            phase_start = sent_count;
            while (sent_count - phase_start < BYTES_PER_PHASE) begin
                // mostly good frames, some broken ones and noise
                if (seq_q.size() == 0) begin
                    roll = $urandom_range(99);
                    if (roll < 70)      kind = SEQ_GOOD;
                    else if (roll < 78) kind = SEQ_BAD_TAIL;
                    else if (roll < 85) kind = SEQ_BAD_LEN;
                    else if (roll < 92) kind = SEQ_CUT;
                    else                kind = SEQ_NOISE;
                    case (kind)
                        SEQ_GOOD:     add_frame($urandom_range(HTFD_MAX_PAYLOAD), 1'b1);
                        SEQ_BAD_TAIL: add_frame($urandom_range(HTFD_MAX_PAYLOAD), 1'b0);
                        SEQ_BAD_LEN: begin
                            add_head();
                            put_byte(8'($urandom_range(255, HTFD_MAX_PAYLOAD + 1)));
                            repeat ($urandom_range(10)) put_byte(pick_content());
                        end
                        SEQ_CUT: begin
                            put_byte(marks.hdr_first);
                            put_byte(marks.hdr_second);
                            repeat ($urandom_range(8)) put_byte(pick_content());
                        end
                        default: begin
                            repeat ($urandom_range(12, 1))
                                put_byte(8'($urandom_range(255)));
                        end
                    endcase
                end
                // send the sequence one item at a time with random gaps
                foreach (seq_q[i]) begin
                    while ($urandom_range(99) < send_idle_pct) begin
                        rx_if.valid <= 1'b0;
                        @(posedge clk);
                    end
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= seq_q[i];
                    do @(posedge clk); while (!rx_if.ready);
                    sent_count++;
                end
                seq_q.delete();
            end

            // let every expected frame come out and the block go quiet
            rx_if.valid <= 1'b0;
            do @(posedge clk); while (pending != 0);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        if (fail_count == 0 && pending == 0)
            $display("header_tail_frame_deframer_top: match");
        else
            $display("header_tail_frame_deframer_top: mismatch");
        $finish;
    end

endmodule

// ===== header_tail_frame_deframer_top.f =====
design/htfd_pkg.sv
design/htfd_in_if.sv
design/htfd_out_if.sv
design/htfd_buffer.sv
design/header_tail_frame_deframer_top.sv
tb/header_tail_frame_deframer_checker.sv
tb/header_tail_frame_deframer_top_tb.sv
